FILE: hw/rtl/pfdma_pkg.sv
// ----------------------------------------------------------------------------
// pfdma_pkg
// Shared widths, register indexes, conversion constants and the request and
// result types of the serial divider for the pressure frame decoder.
// ----------------------------------------------------------------------------
package pfdma_pkg;

  // Field widths.
  localparam int FRAME_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 14;
  localparam int TRAW_W   = 11;
  localparam int FS_W     = 16;
  localparam int TEMP_W   = 12;
  localparam int PRESS_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Temperature conversion: floor(raw * 2000 / 2047) - 500.
  localparam int TPROD_W = 22;
  localparam logic [TPROD_W-1:0] TEMP_GAIN   = 22'd2000;
  localparam logic [TRAW_W:0]    TEMP_DIV    = 12'd2047;
  localparam logic [TEMP_W-1:0]  TEMP_OFFSET = 12'd500;

  // Pressure conversion: count offset times 1000 times full scale.
  localparam int SCALED_W = 24;
  localparam logic [SCALED_W-1:0] PRESS_GAIN = 24'd1000;

  // Divider datapath: 40-bit dividend, 14-bit divisor, 17-bit quotient with a
  // sticky overflow flag for anything that no longer fits.
  localparam int NUM_W   = 40;
  localparam int DEN_W   = 14;
  localparam int QUO_W   = 17;
  localparam int DCNT_W  = 6;
  localparam logic [QUO_W:0] PRESS_OFFSET = 18'd1000;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd2;
  localparam logic [COUNT_W-1:0]   ZERO_COUNT_RST = 14'd1638;
  localparam logic [COUNT_W-1:0]   TOP_COUNT_RST  = 14'd14745;
  localparam logic [FS_W-1:0]      FULL_SCALE_RST = 16'd10;

  // Divider request.
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] numer;
    logic [DEN_W-1:0] denom;
  } div_req_t;

  // Divider result, valid while done is high.
  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [QUO_W-1:0] quot;
  } div_res_t;

endpackage

FILE: hw/rtl/pressure_frame_decode_moving_average.sv
// ----------------------------------------------------------------------------
// pressure_frame_decode_moving_average
// Decodes 4-byte pressure sensor frames, converts temperature and pressure,
// and keeps a moving-average window that a read returns and clears.
// ----------------------------------------------------------------------------
// The block works on one item at a time; in_ready is high while it is idle,
// and a finished result waits in the output register without holding up the
// next transfer. A sample whose status is not zero, or taken while top_count
// does not exceed zero_count, goes straight to the finish state without touching
// the window. A stored sample runs the bit-serial multiply by full_scale, the
// radix-2 divide by the span (one quotient bit per cycle over a 40-bit
// dividend), then the window write and the read of the entry that leaves the
// sum; a count at or below zero_count skips the multiply and the divide. A
// read uses the same divider, working through sum_r / WINDOW_SIZE. Reset
// clears the window at once through one valid flag per entry.
module pressure_frame_decode_moving_average #(
  parameter int WINDOW_SIZE = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pfdma_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pfdma_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Input items.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic [pfdma_pkg::FRAME_W-1:0]       in_sensor_frame,
  // Result items.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pfdma_pkg::PRESS_W-1:0]       out_average_pressure,
  output logic signed [pfdma_pkg::TEMP_W-1:0] out_temperature_tenths,
  output logic [pfdma_pkg::STATUS_W-1:0]      out_sensor_status,
  output logic                                out_sample_stored
);

  localparam int IDX_W = $clog2(WINDOW_SIZE);
  localparam int SUM_W = pfdma_pkg::PRESS_W + IDX_W;
  localparam int MCNT_W = $clog2(pfdma_pkg::FS_W);

  // Sequencer state codes.
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MUL      = 3'd1;
  localparam logic [2:0] S_DIV_GO   = 3'd2;
  localparam logic [2:0] S_DIV_WAIT = 3'd3;
  localparam logic [2:0] S_WR       = 3'd4;
  localparam logic [2:0] S_SUB      = 3'd5;
  localparam logic [2:0] S_FIN      = 3'd6;

  logic [2:0]                          state_r, state_nxt;

  // Configuration registers.
  logic [pfdma_pkg::COUNT_W-1:0]       zero_count_r;
  logic [pfdma_pkg::COUNT_W-1:0]       top_count_r;
  logic [pfdma_pkg::FS_W-1:0]          full_scale_r;

  // Item state.
  logic                                op_r, op_nxt;
  logic                                stored_r, stored_nxt;
  logic [pfdma_pkg::PRESS_W-1:0]       avg_r, avg_nxt;
  logic [pfdma_pkg::PRESS_W-1:0]       press_r, press_nxt;
  logic [pfdma_pkg::DEN_W-1:0]         span_r, span_nxt;
  logic signed [pfdma_pkg::TEMP_W-1:0] last_temp_r, last_temp_nxt;
  logic [pfdma_pkg::STATUS_W-1:0]      last_status_r, last_status_nxt;

  // Serial multiplier.
  logic [pfdma_pkg::NUM_W-1:0]         acc_r, acc_nxt;
  logic [pfdma_pkg::NUM_W-1:0]         mcand_r, mcand_nxt;
  logic [pfdma_pkg::FS_W-1:0]          mplr_r, mplr_nxt;
  logic [MCNT_W-1:0]                   mcnt_r, mcnt_nxt;

  // Window.
  logic [pfdma_pkg::PRESS_W-1:0]       win_mem [WINDOW_SIZE];
  logic [WINDOW_SIZE-1:0]              win_vld_r, win_vld_nxt;
  logic [IDX_W-1:0]                    idx_r, idx_nxt;
  logic [IDX_W-1:0]                    idx_inc;
  logic [SUM_W-1:0]                    sum_r, sum_nxt;
  logic [pfdma_pkg::PRESS_W-1:0]       rd_data_r;
  logic                                rd_vld_r;
  logic                                win_we;

  // Output register.
  logic                                out_valid_r, out_valid_nxt;
  logic [pfdma_pkg::PRESS_W-1:0]       out_avg_r, out_avg_nxt;
  logic signed [pfdma_pkg::TEMP_W-1:0] out_temp_r, out_temp_nxt;
  logic [pfdma_pkg::STATUS_W-1:0]      out_status_r, out_status_nxt;
  logic                                out_stored_r, out_stored_nxt;

  // Frame fields and conversions.
  logic [pfdma_pkg::STATUS_W-1:0]      f_status;
  logic [pfdma_pkg::COUNT_W-1:0]       f_count;
  logic [pfdma_pkg::TRAW_W-1:0]        f_traw;
  logic [pfdma_pkg::TPROD_W-1:0]       t_prod;
  logic [pfdma_pkg::TRAW_W-1:0]        t_q0;
  logic [pfdma_pkg::TRAW_W:0]          t_rem;
  logic [pfdma_pkg::TRAW_W:0]          t_quot;
  logic [pfdma_pkg::TEMP_W-1:0]        t_tenths;
  logic [pfdma_pkg::COUNT_W-1:0]       c_diff;
  logic [pfdma_pkg::SCALED_W-1:0]      c_scaled;
  logic [pfdma_pkg::QUO_W:0]           p_diff;

  pfdma_pkg::div_req_t                 div_req;
  pfdma_pkg::div_res_t                 div_res;

  logic                                in_xfer;
  logic                                out_free;

  assign in_xfer  = in_valid & in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Frame split: status in the top two bits, then the pressure count, then
  // the temperature count in the third byte and the top of the fourth.
  assign f_status = in_sensor_frame[31:30];
  assign f_count  = in_sensor_frame[29:16];
  assign f_traw   = in_sensor_frame[15:5];

  // Temperature: divide by 2047 as a shift by 11 plus one correction step,
  // since the remainder estimate stays below twice the divisor.
  assign t_prod   = pfdma_pkg::TPROD_W'(f_traw) * pfdma_pkg::TEMP_GAIN;
  assign t_q0     = t_prod[pfdma_pkg::TPROD_W-1:pfdma_pkg::TRAW_W];
  assign t_rem    = {1'b0, t_prod[pfdma_pkg::TRAW_W-1:0]} + {1'b0, t_q0};
  assign t_quot   = {1'b0, t_q0} + {{pfdma_pkg::TRAW_W{1'b0}},
                                    (t_rem >= pfdma_pkg::TEMP_DIV)};
  assign t_tenths = t_quot - pfdma_pkg::TEMP_OFFSET;

  // Pressure count above zero, scaled by the fixed gain.
  assign c_diff   = f_count - zero_count_r;
  assign c_scaled = pfdma_pkg::SCALED_W'(c_diff) * pfdma_pkg::PRESS_GAIN;

  // Quotient less the offset; below zero or past 16 bits saturates.
  assign p_diff   = {1'b0, div_res.quot} - pfdma_pkg::PRESS_OFFSET;

  // Ring index after the current one.
  assign idx_inc  = (idx_r == IDX_W'(WINDOW_SIZE - 1)) ? '0 : idx_r + 1'b1;

  // Divider operands: the window sum on reads, the scaled count on samples.
  assign div_req.start = (state_r == S_DIV_GO);
  assign div_req.numer = op_r ? pfdma_pkg::NUM_W'(sum_r) : acc_r;
  assign div_req.denom = op_r ? pfdma_pkg::DEN_W'(WINDOW_SIZE) : span_r;

  pfdma_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  // Sequencer and datapath next state.
  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    stored_nxt      = stored_r;
    avg_nxt         = avg_r;
    press_nxt       = press_r;
    span_nxt        = span_r;
    last_temp_nxt   = last_temp_r;
    last_status_nxt = last_status_r;
    acc_nxt         = acc_r;
    mcand_nxt       = mcand_r;
    mplr_nxt        = mplr_r;
    mcnt_nxt        = mcnt_r;
    win_vld_nxt     = win_vld_r;
    idx_nxt         = idx_r;
    sum_nxt         = sum_r;
    win_we          = 1'b0;
    out_valid_nxt   = out_valid_r & ~out_ready;
    out_avg_nxt     = out_avg_r;
    out_temp_nxt    = out_temp_r;
    out_status_nxt  = out_status_r;
    out_stored_nxt  = out_stored_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt     = in_op;
          stored_nxt = 1'b0;
          avg_nxt    = '0;
          span_nxt   = top_count_r - zero_count_r;
          acc_nxt    = '0;
          mcand_nxt  = pfdma_pkg::NUM_W'(c_scaled);
          mplr_nxt   = full_scale_r;
          mcnt_nxt   = '0;
          press_nxt  = '0;
          if (in_op) begin
            state_nxt = S_DIV_GO;
          end else begin
            last_temp_nxt   = t_tenths;
            last_status_nxt = f_status;
            if (f_status != '0 || top_count_r <= zero_count_r) begin
              state_nxt = S_FIN;
            end else if (f_count <= zero_count_r) begin
              // Count at or below zero pressure saturates to zero.
              state_nxt = S_WR;
            end else begin
              state_nxt = S_MUL;
            end
          end
        end
      end

      // Shift-add multiply by full_scale, one multiplier bit per cycle.
      S_MUL: begin
        acc_nxt   = acc_r + (mplr_r[0] ? mcand_r : '0);
        mcand_nxt = {mcand_r[pfdma_pkg::NUM_W-2:0], 1'b0};
        mplr_nxt  = {1'b0, mplr_r[pfdma_pkg::FS_W-1:1]};
        mcnt_nxt  = mcnt_r + 1'b1;
        if (mcnt_r == MCNT_W'(pfdma_pkg::FS_W - 1)) begin
          state_nxt = S_DIV_GO;
        end
      end

      S_DIV_GO: begin
        state_nxt = S_DIV_WAIT;
      end

      S_DIV_WAIT: begin
        if (div_res.done) begin
          if (op_r) begin
            // Read: return the average and clear the window.
            avg_nxt     = div_res.quot[pfdma_pkg::PRESS_W-1:0];
            sum_nxt     = '0;
            win_vld_nxt = '0;
            state_nxt   = S_FIN;
          end else begin
            // A quotient past the divider width is always above the top.
            if (div_res.ovf) begin
              press_nxt = '1;
            end else if (p_diff[pfdma_pkg::QUO_W]) begin
              press_nxt = '0;
            end else if (p_diff[pfdma_pkg::PRESS_W]) begin
              press_nxt = '1;
            end else begin
              press_nxt = p_diff[pfdma_pkg::PRESS_W-1:0];
            end
            state_nxt = S_WR;
          end
        end
      end

      // Enter the sample, advance the index and fetch the entry there.
      S_WR: begin
        win_we             = 1'b1;
        win_vld_nxt[idx_r] = 1'b1;
        sum_nxt            = sum_r + SUM_W'(press_r);
        idx_nxt            = idx_inc;
        stored_nxt         = 1'b1;
        state_nxt          = S_SUB;
      end

      // Drop the entry at the new index from the sum.
      S_SUB: begin
        sum_nxt   = sum_r - (rd_vld_r ? SUM_W'(rd_data_r) : '0);
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_avg_nxt    = avg_r;
          out_temp_nxt   = last_temp_r;
          out_status_nxt = last_status_r;
          out_stored_nxt = stored_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and window bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      win_vld_r     <= '0;
      idx_r         <= '0;
      sum_r         <= '0;
      last_temp_r   <= '0;
      last_status_r <= '0;
      zero_count_r  <= pfdma_pkg::ZERO_COUNT_RST;
      top_count_r   <= pfdma_pkg::TOP_COUNT_RST;
      full_scale_r  <= pfdma_pkg::FULL_SCALE_RST;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      win_vld_r     <= win_vld_nxt;
      idx_r         <= idx_nxt;
      sum_r         <= sum_nxt;
      last_temp_r   <= last_temp_nxt;
      last_status_r <= last_status_nxt;
      // Configuration writes; indexes past the list are ignored.
      if (cfg_valid) begin
        unique case (cfg_index)
          pfdma_pkg::REG_ZERO_COUNT: zero_count_r <= cfg_data[pfdma_pkg::COUNT_W-1:0];
          pfdma_pkg::REG_TOP_COUNT:  top_count_r  <= cfg_data[pfdma_pkg::COUNT_W-1:0];
          pfdma_pkg::REG_FULL_SCALE: full_scale_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    stored_r     <= stored_nxt;
    avg_r        <= avg_nxt;
    press_r      <= press_nxt;
    span_r       <= span_nxt;
    acc_r        <= acc_nxt;
    mcand_r      <= mcand_nxt;
    mplr_r       <= mplr_nxt;
    mcnt_r       <= mcnt_nxt;
    out_avg_r    <= out_avg_nxt;
    out_temp_r   <= out_temp_nxt;
    out_status_r <= out_status_nxt;
    out_stored_r <= out_stored_nxt;
  end

  // Window memory: one write port, one registered read at the next index.
  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[idx_r] <= press_r;
    end
    rd_data_r <= win_mem[idx_inc];
    rd_vld_r  <= win_vld_r[idx_inc];
  end

  assign cfg_ready              = 1'b1;
  assign in_ready               = (state_r == S_IDLE);
  assign out_valid              = out_valid_r;
  assign out_average_pressure   = out_avg_r;
  assign out_temperature_tenths = out_temp_r;
  assign out_sensor_status      = out_status_r;
  assign out_sample_stored      = out_stored_r;

endmodule

FILE: hw/rtl/pfdma_div.sv
// ----------------------------------------------------------------------------
// pfdma_div
// Restoring radix-2 divider: one quotient bit per cycle over the full dividend
// width. The quotient keeps its low bits and flags any bit shifted off the top.
// ----------------------------------------------------------------------------
module pfdma_div (
  input  logic                clk,
  input  logic                rst_n,
  input  pfdma_pkg::div_req_t req,
  output pfdma_pkg::div_res_t res
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [pfdma_pkg::DCNT_W-1:0]    cnt_r, cnt_nxt;
  logic [pfdma_pkg::NUM_W-1:0]     num_r, num_nxt;
  logic [pfdma_pkg::DEN_W-1:0]     den_r, den_nxt;
  logic [pfdma_pkg::DEN_W-1:0]     rem_r, rem_nxt;
  logic [pfdma_pkg::QUO_W-1:0]     quot_r, quot_nxt;
  logic                            ovf_r, ovf_nxt;
  logic [pfdma_pkg::DEN_W:0]       trial;
  logic [pfdma_pkg::DEN_W:0]       diff;

  // One restoring step: bring down the next dividend bit and try the divisor.
  assign trial = {rem_r, num_r[pfdma_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    ovf_nxt  = ovf_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = req.numer;
      den_nxt  = req.denom;
      rem_nxt  = '0;
      quot_nxt = '0;
      ovf_nxt  = 1'b0;
    end else if (busy_r) begin
      num_nxt  = {num_r[pfdma_pkg::NUM_W-2:0], 1'b0};
      ovf_nxt  = ovf_r | quot_r[pfdma_pkg::QUO_W-1];
      if (!diff[pfdma_pkg::DEN_W]) begin
        rem_nxt  = diff[pfdma_pkg::DEN_W-1:0];
        quot_nxt = {quot_r[pfdma_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt  = trial[pfdma_pkg::DEN_W-1:0];
        quot_nxt = {quot_r[pfdma_pkg::QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == pfdma_pkg::DCNT_W'(pfdma_pkg::NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    ovf_r  <= ovf_nxt;
  end

  assign res.done = done_r;
  assign res.ovf  = ovf_r;
  assign res.quot = quot_r;

endmodule
